@@ rtl/page_bitmap_allocator_core_assert.svh @@
// Assertion macros shared by the page bitmap allocator RTL.
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");

// Check that a condition implies another in the next cycle.
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");

`endif

@@ rtl/pba_pkg.sv @@
// Package with types and constants of the page bitmap allocator.
`default_nettype none
package pba_pkg;

  localparam int NUM_PAGES_DEF = 262144;
  localparam int MAX_RUN_DEF   = 65534;
  localparam int MAP_WORD_W    = 32;
  localparam int KIND_W        = 2;
  localparam int PAGE_W        = 18;
  localparam int LEN_W         = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_MARK_FREE = 2'd0,
    KIND_MARK_USED = 2'd1,
    KIND_ALLOC_ONE = 2'd2,
    KIND_ALLOC_RUN = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MK_RD,
    ST_MK_WR,
    ST_F_RD,
    ST_F_EX,
    ST_R_RD,
    ST_R_EX,
    ST_R_BIT,
    ST_U_RD,
    ST_U_WR
  } state_t;

endpackage
`default_nettype wire

@@ rtl/pba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/page_bitmap_allocator_core.sv @@
// Page bitmap allocator: one free bit per page, word-serial first-fit search.
// Usage:
//   Input channel in_valid/in_ready carries a request word: in_kind selects
//   mark free, mark used, allocate one page or allocate a run of
//   in_run_length pages. Output channel out_valid/out_ready returns out_ok
//   and out_first_page for every request.
//   One request is handled at a time; in_ready is low from acceptance until
//   the result word has been taken.
//   A mark reads its map word and writes it back. Allocating one page reads
//   and examines each map word (32 pages each) in turn. A run search takes
//   words that are all free or all used whole and scans mixed words bit by
//   bit, then reads and writes back each word the run covers.
//   Reset: after rst_n the map RAM is swept to all-used, one word per cycle,
//   over all NUM_PAGES/32 map words (8192 at default), in_ready low meanwhile.
//   Stall: a result waits in the output register while out_ready is low and
//   no new request is taken.
`default_nettype none
module page_bitmap_allocator_core
  import pba_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [PAGE_W-1:0] in_page_number,
  input  wire logic [LEN_W-1:0]  in_run_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_ok,
  output logic [PAGE_W-1:0]      out_first_page
);

  localparam int NUM_WORDS = (NUM_PAGES + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int WAW       = $clog2(NUM_WORDS);
  localparam int PGW       = WAW + 5;
  localparam int CW        = $clog2(MAX_RUN + 33);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(NUM_WORDS - 1);

  // Lowest set bit of a nonzero word
  function automatic logic [4:0] lsb_pos(input logic [31:0] w);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) begin
        pos = 5'(i);
      end
    end
    return pos;
  endfunction

  state_t            st_r, st_nxt;
  logic [WAW-1:0]    addr_r, addr_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [PGW-1:0]    page_r, page_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PGW-1:0]    start_r, start_nxt;
  logic [PGW-1:0]    end_r, end_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [PAGE_W-1:0] out_first_r, out_first_nxt;

  logic        ram_we, ram_re;
  logic [31:0] ram_wdata, ram_rdata;

  logic           accept, in_range, len_ok, last_word, is_zero, is_ones;
  logic           run_fit, bit_free, bit_hit;
  logic [PGW-1:0] base, bit_page, bit_start;
  logic [CW-1:0]  cnt_inc;
  logic [4:0]     mask_lo, mask_hi;
  logic [31:0]    run_mask, page_bit;

  pba_ram #(.WIDTH(MAP_WORD_W), .DEPTH(NUM_WORDS)) u_map (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(addr_r),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(addr_r),
    .rd_data(ram_rdata)
  );

  // Shared decode of the request and of the current map word
  assign in_ready  = (st_r == ST_IDLE) && !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign in_range  = 32'(in_page_number) < 32'(NUM_PAGES);
  assign len_ok    = (in_run_length != '0) && (32'(in_run_length) <= 32'(MAX_RUN));
  assign last_word = addr_r == LAST_WORD;
  assign is_zero   = ram_rdata == 32'h0;
  assign is_ones   = ram_rdata == 32'hFFFF_FFFF;
  assign base      = {addr_r, 5'd0};
  assign run_fit   = (32'(cnt_r) + 32'd32) >= 32'(len_r);
  assign bit_free  = ram_rdata[bit_r];
  assign bit_page  = base | PGW'(bit_r);
  assign bit_start = (cnt_r == '0) ? bit_page : start_r;
  assign cnt_inc   = cnt_r + CW'(1);
  assign bit_hit   = bit_free && (32'(cnt_inc) == 32'(len_r));
  assign page_bit  = 32'h1 << page_r[4:0];
  assign mask_lo   = (addr_r == start_r[PGW-1:5]) ? start_r[4:0] : 5'd0;
  assign mask_hi   = (addr_r == end_r[PGW-1:5]) ? end_r[4:0] : 5'd31;
  assign run_mask  = (32'hFFFF_FFFF << mask_lo) & (32'hFFFF_FFFF >> (5'd31 - mask_hi));

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (last_word) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(in_kind))
            KIND_MARK_FREE, KIND_MARK_USED: if (in_range) st_nxt = ST_MK_RD;
            KIND_ALLOC_ONE: st_nxt = ST_F_RD;
            KIND_ALLOC_RUN: if (len_ok) st_nxt = ST_R_RD;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MK_RD: st_nxt = ST_MK_WR;
      ST_MK_WR: st_nxt = ST_IDLE;
      ST_F_RD:  st_nxt = ST_F_EX;
      ST_F_EX:  st_nxt = (!is_zero || last_word) ? ST_IDLE : ST_F_RD;
      ST_R_RD:  st_nxt = ST_R_EX;
      ST_R_EX: begin
        if (is_ones && run_fit) st_nxt = ST_U_RD;
        else if (!is_zero && !is_ones) st_nxt = ST_R_BIT;
        else st_nxt = last_word ? ST_IDLE : ST_R_RD;
      end
      ST_R_BIT: begin
        if (bit_hit) st_nxt = ST_U_RD;
        else if (bit_r == 5'd31) st_nxt = last_word ? ST_IDLE : ST_R_RD;
      end
      ST_U_RD: st_nxt = ST_U_WR;
      ST_U_WR: st_nxt = (addr_r == end_r[PGW-1:5]) ? ST_IDLE : ST_U_RD;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and result word
  always_comb begin
    addr_nxt      = addr_r;
    kind_nxt      = kind_r;
    page_nxt      = page_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_first_nxt = out_first_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = 32'h0;
    unique case (st_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + WAW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          page_nxt = PGW'(in_page_number);
          len_nxt  = in_run_length;
          cnt_nxt  = '0;
          addr_nxt = '0;
          unique case (kind_t'(in_kind))
            KIND_MARK_FREE, KIND_MARK_USED: begin
              addr_nxt = WAW'(in_page_number >> 5);
              if (!in_range) begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b0;
                out_first_nxt = in_page_number;
              end
            end
            KIND_ALLOC_ONE: ;
            KIND_ALLOC_RUN: begin
              if (!len_ok) begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b0;
                out_first_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MK_RD: ram_re = 1'b1;
      ST_MK_WR: begin
        ram_we        = 1'b1;
        ram_wdata     = (kind_t'(kind_r) == KIND_MARK_FREE) ? (ram_rdata | page_bit)
                                                            : (ram_rdata & ~page_bit);
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_first_nxt = PAGE_W'(page_r);
      end
      ST_F_RD: ram_re = 1'b1;
      ST_F_EX: begin
        if (!is_zero) begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata & ~(32'h1 << lsb_pos(ram_rdata));
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_first_nxt = PAGE_W'(base | PGW'(lsb_pos(ram_rdata)));
        end else if (last_word) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_first_nxt = '0;
        end else begin
          addr_nxt = addr_r + WAW'(1);
        end
      end
      ST_R_RD: ram_re = 1'b1;
      ST_R_EX: begin
        bit_nxt = 5'd0;
        if (is_ones && run_fit) begin
          start_nxt = (cnt_r == '0) ? base : start_r;
          end_nxt   = ((cnt_r == '0) ? base : start_r) + PGW'(len_r) - PGW'(1);
          addr_nxt  = ((cnt_r == '0) ? base[PGW-1:5] : start_r[PGW-1:5]);
        end else if (is_zero || is_ones) begin
          if (is_ones) begin
            start_nxt = (cnt_r == '0) ? base : start_r;
            cnt_nxt   = cnt_r + CW'(32);
          end else begin
            cnt_nxt = '0;
          end
          if (last_word) begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_first_nxt = '0;
          end else begin
            addr_nxt = addr_r + WAW'(1);
          end
        end
      end
      ST_R_BIT: begin
        if (bit_free) begin
          start_nxt = bit_start;
          cnt_nxt   = cnt_inc;
        end else begin
          cnt_nxt = '0;
        end
        if (bit_hit) begin
          end_nxt  = bit_start + PGW'(len_r) - PGW'(1);
          addr_nxt = bit_start[PGW-1:5];
        end else if (bit_r == 5'd31) begin
          if (last_word) begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_first_nxt = '0;
          end else begin
            addr_nxt = addr_r + WAW'(1);
          end
        end else begin
          bit_nxt = bit_r + 5'd1;
        end
      end
      ST_U_RD: ram_re = 1'b1;
      ST_U_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~run_mask;
        if (addr_r == end_r[PGW-1:5]) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_first_nxt = PAGE_W'(start_r);
        end else begin
          addr_nxt = addr_r + WAW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    page_r      <= page_nxt;
    len_r       <= len_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    cnt_r       <= cnt_nxt;
    bit_r       <= bit_nxt;
    out_ok_r    <= out_ok_nxt;
    out_first_r <= out_first_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_first_page = out_first_r;

`include "page_bitmap_allocator_core_assert.svh"

  `PBA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  `PBA_ASSERT_NOW(a_no_write_idle, st_r == ST_IDLE, !ram_we)
  `PBA_ASSERT_NOW(a_no_accept_clear, st_r == ST_CLEAR, !in_ready && !out_valid_r)

endmodule
`default_nettype wire

@@ tb/sv/tb_page_bitmap_allocator_core.sv @@
// Testbench of the page bitmap allocator: random and directed requests, checked against a predictor.
`timescale 1ns / 100ps
module tb_page_bitmap_allocator_core;
  import pba_pkg::*;

  localparam int NUM_WORDS  = NUM_PAGES_DEF / MAP_WORD_W;
  localparam int LOW_PAGES  = 256;
  localparam int NEAR_PAGES = 4096;
  localparam int FAIL_MAX   = 4;
  localparam int BAD_MAX    = 4;
  localparam int RAND_ITEMS = 1500;
  localparam int WD_LIMIT   = 200000;
  localparam int HOLD_LEN   = 500;
  localparam int MAP_PLAN   = 0;
  localparam int MAP_CHECK  = 1;

  typedef struct packed {
    kind_t             kind;
    logic [PAGE_W-1:0] page;
    logic [LEN_W-1:0]  len;
  } request_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] page;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic [LEN_W-1:0] in_run_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [PAGE_W-1:0] out_first_page;

  // Two copies of the free map: one plans the stimulus, one checks the block
  logic [MAP_WORD_W-1:0] free_map [2][NUM_WORDS];

  request_t request_q [$];
  grant_t   grant_q [$];
  bit       in_taken = 1'b0;
  int       n_accepted = 0;
  int       n_granted = 0;
  int       n_failed_grants = 0;
  int       n_mismatch = 0;
  int       idle_cycles = 0;
  int       hold_cnt = 0;
  bit       held = 1'b0;
  int       plan_fails = 0;
  int       plan_bad = 0;

  page_bitmap_allocator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_page_number(in_page_number), .in_run_length(in_run_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ok(out_ok), .out_first_page(out_first_page)
  );

  always #4 clk = ~clk;

  // Apply one request to map m; leave the map untouched unless commit is set
  function automatic grant_t allocate_pages(input int m, input request_t rq, input bit commit);
    grant_t g;
    int w;
    int b;
    int p;
    int cnt;
    int start;
    g.ok = 1'b0;
    g.page = '0;
    case (rq.kind)
      KIND_MARK_FREE, KIND_MARK_USED: begin
        g.ok = 1'b1;
        g.page = rq.page;
        if (commit) free_map[m][rq.page >> 5][rq.page[4:0]] = (rq.kind == KIND_MARK_FREE);
      end
      KIND_ALLOC_ONE: begin
        for (w = 0; w < NUM_WORDS && !g.ok; w++) begin
          if (free_map[m][w] != '0) begin
            for (b = 0; b < MAP_WORD_W && !g.ok; b++) begin
              if (free_map[m][w][b]) begin
                g.ok = 1'b1;
                g.page = PAGE_W'((w << 5) | b);
              end
            end
          end
        end
        if (g.ok && commit) free_map[m][g.page >> 5][g.page[4:0]] = 1'b0;
      end
      default: begin
        if (rq.len != 0 && rq.len <= MAX_RUN_DEF) begin
          cnt = 0;
          start = 0;
          for (w = 0; w < NUM_WORDS && !g.ok; w++) begin
            if (free_map[m][w] == '0) begin
              cnt = 0;
            end else begin
              for (b = 0; b < MAP_WORD_W && !g.ok; b++) begin
                if (free_map[m][w][b]) begin
                  if (cnt == 0) start = (w << 5) | b;
                  cnt++;
                  if (cnt == rq.len) begin
                    g.ok = 1'b1;
                    g.page = PAGE_W'(start);
                  end
                end else begin
                  cnt = 0;
                end
              end
            end
          end
          if (g.ok && commit) begin
            for (p = start; p < start + rq.len; p++) free_map[m][p >> 5][p % 32] = 1'b0;
          end
        end
      end
    endcase
    return g;
  endfunction

  task automatic push_request(input kind_t k, input int pg, input int len);
    request_t rq;
    grant_t g;
    rq.kind = k;
    rq.page = PAGE_W'(pg);
    rq.len = LEN_W'(len);
    g = allocate_pages(MAP_PLAN, rq, 1'b1);
    request_q.push_back(rq);
  endtask

  // Build random requests mostly in the low pages, keeping full-map scans rare
  task automatic push_random(input int n);
    request_t rq;
    grant_t g;
    int i;
    int r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      rq.page = ($urandom_range(0, 19) == 0) ? PAGE_W'($urandom)
                                             : PAGE_W'($urandom_range(0, LOW_PAGES - 1));
      rq.len = LEN_W'($urandom);
      if (r < 35) rq.kind = KIND_MARK_FREE;
      else if (r < 50) rq.kind = KIND_MARK_USED;
      else if (r < 75) rq.kind = KIND_ALLOC_ONE;
      else begin
        rq.kind = KIND_ALLOC_RUN;
        if (plan_bad < BAD_MAX && $urandom_range(0, 199) == 0) begin
          rq.len = $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'(16'hFFFF);
          plan_bad++;
        end else if ($urandom_range(0, 29) == 0) rq.len = LEN_W'($urandom_range(9, 40));
        else rq.len = LEN_W'($urandom_range(1, 8));
      end
      if (rq.kind == KIND_ALLOC_ONE || rq.kind == KIND_ALLOC_RUN) begin
        g = allocate_pages(MAP_PLAN, rq, 1'b0);
        if (!g.ok && rq.len != 0 && rq.len <= MAX_RUN_DEF) begin
          if (plan_fails < FAIL_MAX) plan_fails++;
          else rq.kind = KIND_MARK_FREE;
        end else if (g.ok && g.page >= NEAR_PAGES) begin
          rq.kind = KIND_MARK_FREE;
        end
        if (rq.kind == KIND_MARK_FREE) rq.page = PAGE_W'($urandom_range(0, LOW_PAGES - 1));
      end
      g = allocate_pages(MAP_PLAN, rq, 1'b1);
      request_q.push_back(rq);
    end
  endtask

  function automatic bit quiet_window();
    return n_accepted >= 700 && n_accepted < 900;
  endfunction

  // Sample both channels, predict accepted requests, check returned words
  always @(posedge clk) begin
    grant_t g;
    request_t rq;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rq.kind = kind_t'(in_kind);
        rq.page = in_page_number;
        rq.len = in_run_length;
        grant_q.push_back(allocate_pages(MAP_CHECK, rq, 1'b1));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected word: ok=%0d page=%0d", out_ok, out_first_page);
        end else begin
          g = grant_q.pop_front();
          if (g.ok) n_granted++;
          else n_failed_grants++;
          if (out_ok !== g.ok || out_first_page !== g.page) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: expected ok=%0d page=%0d, got ok=%0d page=%0d",
                       g.ok, g.page, out_ok, out_first_page);
          end
        end
      end
      // Watchdog: count cycles with no word moving on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else if (idle_cycles + 1 >= WD_LIMIT) begin
        $display("timeout after %0d idle cycles", WD_LIMIT);
        $display("tb: failure");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive the next request word, holding it until accepted
  always @(negedge clk) begin
    request_t rq;
    if (rst_n && (!in_valid || in_taken)) begin
      if (request_q.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 23)) begin
        rq = request_q.pop_front();
        in_valid <= 1'b1;
        in_kind <= rq.kind;
        in_page_number <= rq.page;
        in_run_length <= rq.len;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!held && n_accepted >= 300) begin
      held <= 1'b1;
      hold_cnt <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || ($urandom_range(0, 99) >= 23);
    end
  end

  initial begin
    int i;
    for (i = 0; i < NUM_WORDS; i++) begin
      free_map[MAP_PLAN][i] = '0;
      free_map[MAP_CHECK][i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty map, bad lengths, last-word run, low pages
    push_request(KIND_ALLOC_ONE, 18'h3FFFF, 16'hFFFF);
    push_request(KIND_ALLOC_RUN, 0, 1);
    push_request(KIND_ALLOC_RUN, 0, 0);
    push_request(KIND_ALLOC_RUN, 0, 16'hFFFF);
    push_request(KIND_ALLOC_RUN, 0, MAX_RUN_DEF);
    for (i = 262140; i < 262144; i++) push_request(KIND_MARK_FREE, i, 0);
    push_request(KIND_ALLOC_RUN, 0, 4);
    for (i = 0; i < 16; i++) push_request(KIND_MARK_FREE, i, 16'hFFFF);
    push_request(KIND_ALLOC_ONE, 0, 0);
    push_request(KIND_ALLOC_RUN, 18'h3FFFF, 3);
    push_request(KIND_MARK_USED, 5, 0);
    push_request(KIND_ALLOC_RUN, 0, 6);
    push_request(KIND_MARK_USED, 18'h3FFFF, 0);
    push_random(RAND_ITEMS / 2);

    // Pause the sender until the block has drained
    while (request_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
    push_random(RAND_ITEMS - RAND_ITEMS / 2);

    while (request_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d requests: %0d granted, %0d refused, %0d mismatches",
             n_accepted, n_granted, n_failed_grants, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
